/* rtl/md2_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_pkg
// Shared types, constants and the substitution table of the MD2 digest block.
// ----------------------------------------------------------------------------
package md2_pkg;

    // Geometry of the compression function.
    localparam int unsigned BLOCK_BYTES = 16;
    localparam int unsigned WORK_BYTES  = 48;
    localparam int unsigned ROUNDS      = 18;

    // Address widths of the two state memories.
    localparam int unsigned WK_AW  = 6;
    localparam int unsigned AUX_AW = 5;

    // Fixed addresses and counts used by the sequencer.
    localparam logic [WK_AW-1:0] WK_LAST      = 6'd47;
    localparam logic [WK_AW-1:0] WK_DATA_BASE = 6'd16;
    localparam logic [WK_AW-1:0] WK_XOR_PREV  = 6'd31;
    localparam logic [4:0]       ROUND_LAST   = 5'd17;
    localparam logic [3:0]       BYTE_LAST    = 4'd15;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } byte_item_t;

    // One result item.
    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } digest_item_t;

    // Access request to the work memory.
    typedef struct packed {
        logic             we;
        logic [WK_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic [WK_AW-1:0] raddr;
        logic             clr;
    } wk_req_t;

    // Access request to the pending block / checksum memory.
    typedef struct packed {
        logic              we;
        logic [AUX_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic [AUX_AW-1:0] raddr_a;
        logic [AUX_AW-1:0] raddr_b;
        logic              clr;
    } aux_req_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD,
        S_CPRE,
        S_CA,
        S_CB,
        S_CLAST,
        S_RND,
        S_DRD,
        S_EMIT
    } md2_state_t;

    // MD2 substitution table built from the digits of pi.
    localparam logic [7:0] SBOX [256] = '{
        8'h29, 8'h2E, 8'h43, 8'hC9, 8'hA2, 8'hD8, 8'h7C, 8'h01,
        8'h3D, 8'h36, 8'h54, 8'hA1, 8'hEC, 8'hF0, 8'h06, 8'h13,
        8'h62, 8'hA7, 8'h05, 8'hF3, 8'hC0, 8'hC7, 8'h73, 8'h8C,
        8'h98, 8'h93, 8'h2B, 8'hD9, 8'hBC, 8'h4C, 8'h82, 8'hCA,
        8'h1E, 8'h9B, 8'h57, 8'h3C, 8'hFD, 8'hD4, 8'hE0, 8'h16,
        8'h67, 8'h42, 8'h6F, 8'h18, 8'h8A, 8'h17, 8'hE5, 8'h12,
        8'hBE, 8'h4E, 8'hC4, 8'hD6, 8'hDA, 8'h9E, 8'hDE, 8'h49,
        8'hA0, 8'hFB, 8'hF5, 8'h8E, 8'hBB, 8'h2F, 8'hEE, 8'h7A,
        8'hA9, 8'h68, 8'h79, 8'h91, 8'h15, 8'hB2, 8'h07, 8'h3F,
        8'h94, 8'hC2, 8'h10, 8'h89, 8'h0B, 8'h22, 8'h5F, 8'h21,
        8'h80, 8'h7F, 8'h5D, 8'h9A, 8'h5A, 8'h90, 8'h32, 8'h27,
        8'h35, 8'h3E, 8'hCC, 8'hE7, 8'hBF, 8'hF7, 8'h97, 8'h03,
        8'hFF, 8'h19, 8'h30, 8'hB3, 8'h48, 8'hA5, 8'hB5, 8'hD1,
        8'hD7, 8'h5E, 8'h92, 8'h2A, 8'hAC, 8'h56, 8'hAA, 8'hC6,
        8'h4F, 8'hB8, 8'h38, 8'hD2, 8'h96, 8'hA4, 8'h7D, 8'hB6,
        8'h76, 8'hFC, 8'h6B, 8'hE2, 8'h9C, 8'h74, 8'h04, 8'hF1,
        8'h45, 8'h9D, 8'h70, 8'h59, 8'h64, 8'h71, 8'h87, 8'h20,
        8'h86, 8'h5B, 8'hCF, 8'h65, 8'hE6, 8'h2D, 8'hA8, 8'h02,
        8'h1B, 8'h60, 8'h25, 8'hAD, 8'hAE, 8'hB0, 8'hB9, 8'hF6,
        8'h1C, 8'h46, 8'h61, 8'h69, 8'h34, 8'h40, 8'h7E, 8'h0F,
        8'h55, 8'h47, 8'hA3, 8'h23, 8'hDD, 8'h51, 8'hAF, 8'h3A,
        8'hC3, 8'h5C, 8'hF9, 8'hCE, 8'hBA, 8'hC5, 8'hEA, 8'h26,
        8'h2C, 8'h53, 8'h0D, 8'h6E, 8'h85, 8'h28, 8'h84, 8'h09,
        8'hD3, 8'hDF, 8'hCD, 8'hF4, 8'h41, 8'h81, 8'h4D, 8'h52,
        8'h6A, 8'hDC, 8'h37, 8'hC8, 8'h6C, 8'hC1, 8'hAB, 8'hFA,
        8'h24, 8'hE1, 8'h7B, 8'h08, 8'h0C, 8'hBD, 8'hB1, 8'h4A,
        8'h78, 8'h88, 8'h95, 8'h8B, 8'hE3, 8'h63, 8'hE8, 8'h6D,
        8'hE9, 8'hCB, 8'hD5, 8'hFE, 8'h3B, 8'h00, 8'h1D, 8'h39,
        8'hF2, 8'hEF, 8'hB7, 8'h0E, 8'h66, 8'h58, 8'hD0, 8'hE4,
        8'hA6, 8'h77, 8'h72, 8'hF8, 8'hEB, 8'h75, 8'h4B, 8'h0A,
        8'h31, 8'h44, 8'h50, 8'hB4, 8'h8F, 8'hED, 8'h1F, 8'h1A,
        8'hDB, 8'h99, 8'h8D, 8'h33, 8'h9F, 8'h11, 8'h83, 8'h14
    };

    // Table lookup.
    function automatic logic [7:0] sbox_lookup(input logic [7:0] idx);
        return SBOX[idx];
    endfunction

endpackage
`default_nettype wire

/* rtl/md2_work_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_work_store
// The 48-byte work memory. Entries 0 to 15 hold the chaining value between
// blocks; valid bits make entries unwritten since reset or a clear read as zero.
// ----------------------------------------------------------------------------
module md2_work_store
    import md2_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire wk_req_t    req,
    output logic      [7:0] rdata
);

    logic [7:0]  mem [WORK_BYTES];
    logic [7:0]  rdata_reg;
    logic        zero_reg;
    logic [15:0] chain_vld_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    // Valid bits of the chaining region and the mask flag of the read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_vld_reg <= '0;
            zero_reg      <= 1'b0;
        end
        else
        begin
            zero_reg <= (req.raddr[5:4] == 2'b00) && !chain_vld_reg[req.raddr[3:0]];
            if (req.clr)
            begin
                chain_vld_reg <= '0;
            end
            else if (req.we && (req.waddr[5:4] == 2'b00))
            begin
                chain_vld_reg[req.waddr[3:0]] <= 1'b1;
            end
        end
    end

    assign rdata = zero_reg ? 8'h00 : rdata_reg;

endmodule
`default_nettype wire

/* rtl/md2_aux_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_aux_store
// Pending block (entries 0 to 15) and running checksum (entries 16 to 31),
// one write port and two registered read ports. Checksum entries carry
// valid bits so that they read as zero until written.
// ----------------------------------------------------------------------------
module md2_aux_store
    import md2_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire aux_req_t   req,
    output logic      [7:0] rdata_a,
    output logic      [7:0] rdata_b
);

    logic [7:0]  mem [2 * BLOCK_BYTES];
    logic [7:0]  rdata_a_reg;
    logic [7:0]  rdata_b_reg;
    logic        zero_a_reg;
    logic        zero_b_reg;
    logic [15:0] cks_vld_reg;

    // Synchronous write and two registered reads.
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_a_reg <= mem[req.raddr_a];
        rdata_b_reg <= mem[req.raddr_b];
    end

    // Checksum valid bits and the mask flags of both reads.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cks_vld_reg <= '0;
            zero_a_reg  <= 1'b0;
            zero_b_reg  <= 1'b0;
        end
        else
        begin
            zero_a_reg <= req.raddr_a[4] && !cks_vld_reg[req.raddr_a[3:0]];
            zero_b_reg <= req.raddr_b[4] && !cks_vld_reg[req.raddr_b[3:0]];
            if (req.clr)
            begin
                cks_vld_reg <= '0;
            end
            else if (req.we && req.waddr[4])
            begin
                cks_vld_reg[req.waddr[3:0]] <= 1'b1;
            end
        end
    end

    assign rdata_a = zero_a_reg ? 8'h00 : rdata_a_reg;
    assign rdata_b = zero_b_reg ? 8'h00 : rdata_b_reg;

endmodule
`default_nettype wire

/* rtl/md2_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_ctrl
// Sequencer and byte datapath: absorbs bytes, pads, runs the compression
// one S-box step per cycle over the work memory, and assembles the digest.
// ----------------------------------------------------------------------------
module md2_ctrl
    import md2_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire byte_item_t   byte_item,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_item_t      digest_item,
    output wk_req_t           wk_req,
    input  wire logic   [7:0] wk_rdata,
    output aux_req_t          aux_req,
    input  wire logic   [7:0] aux_rdata_a,
    input  wire logic   [7:0] aux_rdata_b
);

    md2_state_t   state_reg, state_next;
    logic [5:0]   k_reg, k_next;
    logic [4:0]   r_reg, r_next;
    logic [7:0]   t_reg, t_next;
    logic [7:0]   l_reg, l_next;
    logic [7:0]   x_reg, x_next;
    logic [7:0]   pad_reg, pad_next;
    logic [3:0]   fill_reg, fill_next;
    logic         last_reg, last_next;
    logic         padded_reg, padded_next;
    logic         src_cks_reg, src_cks_next;
    logic         out_vld_reg, out_vld_next;
    logic [127:0] dig_reg, dig_next;
    digest_item_t out_item_reg, out_item_next;
    logic         out_load;
    logic [7:0]   step_val;
    logic [7:0]   cks_val;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            r_reg       <= '0;
            fill_reg    <= '0;
            last_reg    <= 1'b0;
            padded_reg  <= 1'b0;
            src_cks_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            r_reg       <= r_next;
            fill_reg    <= fill_next;
            last_reg    <= last_next;
            padded_reg  <= padded_next;
            src_cks_reg <= src_cks_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        t_reg        <= t_next;
        l_reg        <= l_next;
        x_reg        <= x_next;
        pad_reg      <= pad_next;
        dig_reg      <= dig_next;
        out_item_reg <= out_item_next;
    end

    // One chaining step and one checksum step.
    assign step_val = wk_rdata ^ sbox_lookup(t_reg);
    assign cks_val  = aux_rdata_b ^ sbox_lookup(aux_rdata_a ^ l_reg);

    // Next state, memory requests and output register.
    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        r_next        = r_reg;
        t_next        = t_reg;
        l_next        = l_reg;
        x_next        = x_reg;
        pad_next      = pad_reg;
        fill_next     = fill_reg;
        last_next     = last_reg;
        padded_next   = padded_reg;
        src_cks_next  = src_cks_reg;
        dig_next      = dig_reg;
        out_item_next = out_item_reg;
        out_load      = 1'b0;
        wk_req        = '0;
        aux_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (byte_valid)
                begin
                    if (byte_item.has_byte)
                    begin
                        aux_req.we    = 1'b1;
                        aux_req.waddr = {1'b0, fill_reg};
                        aux_req.wdata = byte_item.data_byte;
                        fill_next     = fill_reg + 4'd1;
                        if (fill_reg == BYTE_LAST)
                        begin
                            src_cks_next = 1'b0;
                            last_next    = byte_item.is_last;
                            padded_next  = 1'b0;
                            state_next   = S_CPRE;
                        end
                        else if (byte_item.is_last)
                        begin
                            pad_next   = {4'h0, BYTE_LAST - fill_reg};
                            last_next  = 1'b1;
                            state_next = S_PAD;
                        end
                    end
                    else if (byte_item.is_last)
                    begin
                        pad_next   = {3'b000, 5'd16 - {1'b0, fill_reg}};
                        last_next  = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end

            // Fill the rest of the pending block with the pad value.
            S_PAD:
            begin
                aux_req.we    = 1'b1;
                aux_req.waddr = {1'b0, fill_reg};
                aux_req.wdata = pad_reg;
                fill_next     = fill_reg + 4'd1;
                if (fill_reg == BYTE_LAST)
                begin
                    src_cks_next = 1'b0;
                    padded_next  = 1'b1;
                    state_next   = S_CPRE;
                end
            end

            // Fetch the last checksum byte as the initial link value.
            S_CPRE:
            begin
                aux_req.raddr_b = {1'b1, BYTE_LAST};
                k_next          = '0;
                state_next      = S_CA;
            end

            // Load phase, first half: issue reads, store the previous XOR byte.
            S_CA:
            begin
                if (k_reg == 6'd0)
                begin
                    l_next = aux_rdata_b;
                end
                else
                begin
                    wk_req.we    = 1'b1;
                    wk_req.waddr = k_reg + WK_XOR_PREV;
                    wk_req.wdata = x_reg;
                end
                wk_req.raddr    = k_reg;
                aux_req.raddr_a = {src_cks_reg, k_reg[3:0]};
                aux_req.raddr_b = {1'b1, k_reg[3:0]};
                state_next      = S_CB;
            end

            // Load phase, second half: data byte, XOR byte, checksum update.
            S_CB:
            begin
                wk_req.we     = 1'b1;
                wk_req.waddr  = k_reg + WK_DATA_BASE;
                wk_req.wdata  = aux_rdata_a;
                x_next        = wk_rdata ^ aux_rdata_a;
                aux_req.we    = 1'b1;
                aux_req.waddr = {1'b1, k_reg[3:0]};
                aux_req.wdata = cks_val;
                l_next        = cks_val;
                if (k_reg[3:0] == BYTE_LAST)
                begin
                    state_next = S_CLAST;
                end
                else
                begin
                    k_next     = k_reg + 6'd1;
                    state_next = S_CA;
                end
            end

            // Store the last XOR byte and prime the first round read.
            S_CLAST:
            begin
                wk_req.we    = 1'b1;
                wk_req.waddr = WK_LAST;
                wk_req.wdata = x_reg;
                wk_req.raddr = '0;
                k_next       = '0;
                r_next       = '0;
                t_next       = 8'h00;
                state_next   = S_RND;
            end

            // One S-box step per cycle; the next entry is read in parallel.
            S_RND:
            begin
                wk_req.we    = 1'b1;
                wk_req.waddr = k_reg;
                wk_req.wdata = step_val;
                if (k_reg == WK_LAST)
                begin
                    wk_req.raddr = '0;
                    t_next       = step_val + {3'b000, r_reg};
                    k_next       = '0;
                    if (r_reg == ROUND_LAST)
                    begin
                        if (src_cks_reg)
                        begin
                            state_next = S_DRD;
                        end
                        else if (last_reg && !padded_reg)
                        begin
                            pad_next   = 8'd16;
                            state_next = S_PAD;
                        end
                        else if (last_reg)
                        begin
                            src_cks_next = 1'b1;
                            state_next   = S_CPRE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 5'd1;
                    end
                end
                else
                begin
                    wk_req.raddr = k_reg + 6'd1;
                    t_next       = step_val;
                    k_next       = k_reg + 6'd1;
                end
            end

            // Read the chaining value out, byte 0 first.
            S_DRD:
            begin
                wk_req.raddr = {2'b00, k_reg[3:0]};
                if (k_reg != 6'd0)
                begin
                    dig_next = {dig_reg[119:0], wk_rdata};
                end
                if (k_reg == WK_DATA_BASE)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    k_next = k_reg + 6'd1;
                end
            end

            // Hand the digest to the output register and start over.
            S_EMIT:
            begin
                if (!out_vld_reg || !digest_stall)
                begin
                    out_load                  = 1'b1;
                    out_item_next.digest_high = dig_reg[127:64];
                    out_item_next.digest_low  = dig_reg[63:0];
                    wk_req.clr                = 1'b1;
                    aux_req.clr               = 1'b1;
                    fill_next                 = '0;
                    last_next                 = 1'b0;
                    padded_next               = 1'b0;
                    src_cks_next              = 1'b0;
                    state_next                = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !digest_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign byte_stall   = (state_reg != S_IDLE);
    assign digest_valid = out_vld_reg;
    assign digest_item  = out_item_reg;

endmodule
`default_nettype wire

/* rtl/md2_message_digest.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_message_digest
// MD2 message digest engine, one message byte per input item.
// ----------------------------------------------------------------------------
// Usage:
//   The byte channel (byte_valid, byte_stall, byte_item) takes one item per
//   message byte; has_byte = 0 with is_last = 1 ends a message without a byte.
//   An item is taken on a clock edge with valid high and stall low.
//   A byte that neither completes a 16-byte block nor ends the message
//   leaves the engine ready. The 16th byte starts a compression: the work
//   block is built and the checksum updated, then 864 S-box steps, one per
//   cycle, each a read-modify-write of the single-port-write work memory.
//   The last item adds the padding of the pending block, the padding
//   compression (after the data compression when the last byte filled a
//   block), the checksum compression, the read-out of the digest and the
//   load of the output register. The engine takes no byte during any of this.
//   The digest channel (digest_valid, digest_stall, digest_item) presents
//   one item per message from an output register; while it is stalled the
//   engine still accepts and hashes the next message, and only waits at
//   the end of that message until the register is free.
//   After reset, and after each digest, the engine holds the initial state.
// ----------------------------------------------------------------------------
module md2_message_digest
    import md2_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         byte_valid,
    output logic              byte_stall,
    input  wire byte_item_t   byte_item,
    output logic              digest_valid,
    input  wire logic         digest_stall,
    output digest_item_t      digest_item
);

    wk_req_t    wk_req;
    aux_req_t   aux_req;
    logic [7:0] wk_rdata;
    logic [7:0] aux_rdata_a;
    logic [7:0] aux_rdata_b;

    // Sequencer and datapath.
    md2_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item),
        .wk_req       (wk_req),
        .wk_rdata     (wk_rdata),
        .aux_req      (aux_req),
        .aux_rdata_a  (aux_rdata_a),
        .aux_rdata_b  (aux_rdata_b)
    );

    // Work block and chaining value.
    md2_work_store u_work (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wk_req),
        .rdata (wk_rdata)
    );

    // Pending block and running checksum.
    md2_aux_store u_aux (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (aux_req),
        .rdata_a (aux_rdata_a),
        .rdata_b (aux_rdata_b)
    );

endmodule
`default_nettype wire

/* rtl/md2_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// md2_checker
// Port-level assertions for the MD2 digest engine, bound to the top level.
// ----------------------------------------------------------------------------
module md2_checker
    import md2_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         byte_valid,
    input wire logic         byte_stall,
    input wire byte_item_t   byte_item,
    input wire logic         digest_valid,
    input wire logic         digest_stall,
    input wire digest_item_t digest_item
);

    logic byte_take;

    assign byte_take = byte_valid && !byte_stall;

    // A stalled digest item stays offered.
    a_digest_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> digest_valid)
        else $error("digest item dropped while stalled");

    // A stalled digest item keeps its value.
    a_digest_stable: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid && digest_stall |=> $stable(digest_item))
        else $error("digest item changed while stalled");

    // An empty item that does not end the message leaves the engine ready.
    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        byte_take && !byte_item.has_byte && !byte_item.is_last |=> !byte_stall)
        else $error("engine busy after an empty item");

    // Ending a message always leaves the engine busy with padding and the final compressions.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_take && byte_item.is_last |=> byte_stall)
        else $error("engine ready right after the last item");

endmodule

bind md2_message_digest md2_checker u_md2_checker (.*);
`default_nettype wire
